// ===== rtl/tlca_pkg.sv =====
`default_nettype none

package tlca_pkg;

  localparam int NODE_W          = 18;
  localparam int DEPTH_W         = 18;
  localparam int PATH_W          = 19;
  localparam int ENTRY_W         = NODE_W + 1;
  localparam int MAX_NODES_DEF   = 262144;
  localparam int LIFT_LEVELS_DEF = 18;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = '1;
  localparam logic [PATH_W-1:0]  PATH_MAX   = '1;
  // top bit of an ancestor entry flags "no ancestor that far up"
  localparam logic [ENTRY_W-1:0] NONE_ENTRY = {1'b1, {NODE_W{1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ROOT  = 2'd1,
    OP_QUERY = 2'd2
  } tlca_op_e;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other;
    logic              is_root;
  } tlca_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [PATH_W-1:0] path_nodes;
  } tlca_res_t;

  typedef struct packed {
    tlca_op_e          op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } tlca_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlca_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/tlca_front.sv =====
`default_nettype none

module tlca_front #(
  parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tlca_pkg::tlca_in_t    item_i,
  input  tlca_pkg::tlca_qstat_t q_stat_i,
  output logic                  push_o,
  output tlca_pkg::tlca_cmd_t   cmd_o
);

  localparam int NW      = tlca_pkg::NODE_W;
  localparam bit DO_WRAP = (MAX_NODES < (2 ** NW));
  localparam int RC_W    = 2;
  // node wrap: reciprocal quotient estimate, subtract, one final correction
  localparam logic [RC_W-1:0] RED_MUL  = 2'd3;
  localparam logic [RC_W-1:0] RED_SUB  = 2'd2;
  localparam logic [RC_W-1:0] RED_FIX  = 2'd1;
  localparam logic [RC_W-1:0] RED_INIT = DO_WRAP ? RED_MUL : 2'd0;
  localparam logic [NW-1:0]   RECIP    = NW'((2 ** NW) / MAX_NODES);
  localparam logic [NW-1:0]   MOD_N    = NW'(MAX_NODES);

  logic                fr_valid_q, fr_valid_d;
  logic [RC_W-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]       qa_q, qb_q;
  logic [NW-1:0]       ra_q, rb_q;
  tlca_pkg::tlca_op_e  op_q;
  logic                accept;

  // quotient estimate, never above the true quotient and at most one below
  function automatic logic [NW-1:0] quot_est(input logic [NW-1:0] v);
    logic [2*NW-1:0] p;
    p = {{NW{1'b0}}, v} * {{NW{1'b0}}, RECIP};
    return p[2*NW-1:NW];
  endfunction

  function automatic logic [NW-1:0] sub_quot(input logic [NW-1:0] v,
                                              input logic [NW-1:0] q);
    logic [2*NW-1:0] p;
    p = {{NW{1'b0}}, q} * {{NW{1'b0}}, MOD_N};
    return v - p[NW-1:0];
  endfunction

  function automatic logic [NW-1:0] fix_rem(input logic [NW-1:0] v);
    return (v >= MOD_N) ? (v - MOD_N) : v;
  endfunction

  assign accept = start && !fr_valid_q;
  assign busy   = fr_valid_q;
  assign push_o = fr_valid_q && (cnt_q == '0) && !q_stat_i.full;
  assign cmd_o  = '{op: op_q, a: ra_q, b: rb_q};

  always_comb begin
    fr_valid_d = fr_valid_q;
    cnt_d      = cnt_q;
    if (accept) begin
      fr_valid_d = 1'b1;
      cnt_d      = RED_INIT;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - RC_W'(1);
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      fr_valid_q <= fr_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ra_q <= item_i.node;
      rb_q <= item_i.other;
      if (item_i.action == tlca_pkg::ACT_QUERY) begin
        op_q <= tlca_pkg::OP_QUERY;
      end else if (item_i.is_root) begin
        op_q <= tlca_pkg::OP_ROOT;
      end else begin
        op_q <= tlca_pkg::OP_LOAD;
      end
    end else if (cnt_q == RED_MUL) begin
      qa_q <= quot_est(ra_q);
      qb_q <= quot_est(rb_q);
    end else if (cnt_q == RED_SUB) begin
      ra_q <= sub_quot(ra_q, qa_q);
      rb_q <= sub_quot(rb_q, qb_q);
    end else if (cnt_q == RED_FIX) begin
      ra_q <= fix_rem(ra_q);
      rb_q <= fix_rem(rb_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlca_queue.sv =====
`default_nettype none

module tlca_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tlca_pkg::tlca_cmd_t   cmd_i,
  input  logic                  pop_i,
  output tlca_pkg::tlca_qstat_t stat_o,
  output tlca_pkg::tlca_cmd_t   cmd_o
);

  localparam int QD   = tlca_pkg::QUEUE_DEPTH;
  localparam int QA_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC_W = $clog2(QD + 1);

  tlca_pkg::tlca_cmd_t slots_q [QD];
  logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QC_W'(QD));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QA_W'(QD - 1)) ? '0 : wr_ptr_q + QA_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QA_W'(QD - 1)) ? '0 : rd_ptr_q + QA_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlca_back.sv =====
`default_nettype none

module tlca_back #(
  parameter int MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlca_pkg::tlca_qstat_t q_stat_i,
  input  tlca_pkg::tlca_cmd_t   cmd_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output tlca_pkg::tlca_res_t   res_o
);

  localparam int NW    = tlca_pkg::NODE_W;
  localparam int DW    = tlca_pkg::DEPTH_W;
  localparam int EW    = tlca_pkg::ENTRY_W;
  localparam int PW    = tlca_pkg::PATH_W;
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int LVL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int CNT_W = $clog2(LIFT_LEVELS + 1);
  localparam logic [CNT_W-1:0] LAST_LVL = CNT_W'(LIFT_LEVELS - 1);
  localparam logic [CNT_W-1:0] NUM_LVL  = CNT_W'(LIFT_LEVELS);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_ROOT   = 12'b0000_0000_0010,
    ST_LD_RD  = 12'b0000_0000_0100,
    ST_LD_LVL = 12'b0000_0000_1000,
    ST_Q_DEP  = 12'b0000_0001_0000,
    ST_Q_SW   = 12'b0000_0010_0000,
    ST_Q_UP   = 12'b0000_0100_0000,
    ST_Q_EQ   = 12'b0000_1000_0000,
    ST_Q_TOP  = 12'b0001_0000_0000,
    ST_Q_DN   = 12'b0010_0000_0000,
    ST_Q_PAR  = 12'b0100_0000_0000,
    ST_Q_FIN  = 12'b1000_0000_0000
  } state_e;

  logic [DW-1:0] dep_mem [MAX_NODES];
  logic [EW-1:0] anc_mem [LIFT_LEVELS][MAX_NODES];

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic                res_valid_q, res_valid_d;
  logic [NW-1:0]       a_q, a_d, b_q, b_d, c_q, c_d;
  logic [EW-1:0]       half_q, half_d;
  logic [DW-1:0]       dhi_q, dhi_d, dlo_q, dlo_d, diff_q, diff_d;
  tlca_pkg::tlca_res_t res_q, res_d;

  logic [NW-1:0]    dep_ra_a, dep_ra_b, dep_wa;
  logic             dep_we;
  logic [DW-1:0]    dep_wd, dep_rd_a_q, dep_rd_b_q;
  logic [CNT_W-1:0] anc_rl_a, anc_rl_b, anc_wl;
  logic [NW-1:0]    anc_rn_a, anc_rn_b, anc_wn;
  logic             anc_we, anc_byp;
  logic [EW-1:0]    anc_wd, anc_rd_a_q, anc_rd_b_q;

  logic [CNT_W-1:0] top_lvl, dn_lvl;
  logic [EW-1:0]    lvl_val;
  logic [NW-1:0]    up_node, dn_a, dn_b, par_node;
  logic             dn_move;
  logic [PW:0]      path_sum, path_twice, path_diff;
  logic [PW-1:0]    path_val;

  // highest level whose jump does not exceed the depth
  always_comb begin
    top_lvl = '0;
    for (int i = 1; i < DW; i++) begin
      if (((dep_rd_a_q >> i) != '0) && (i < LIFT_LEVELS)) begin
        top_lvl = CNT_W'(i);
      end
    end
  end

  assign lvl_val  = half_q[NW] ? tlca_pkg::NONE_ENTRY : anc_rd_a_q;
  assign up_node  = (diff_q[0] && !anc_rd_a_q[NW]) ? anc_rd_a_q[NW-1:0] : a_q;
  assign dn_move  = (anc_rd_a_q != anc_rd_b_q) && !anc_rd_a_q[NW] && !anc_rd_b_q[NW];
  assign dn_a     = dn_move ? anc_rd_a_q[NW-1:0] : a_q;
  assign dn_b     = dn_move ? anc_rd_b_q[NW-1:0] : b_q;
  assign dn_lvl   = (k_q == '0) ? '0 : k_q - CNT_W'(1);
  assign par_node = anc_rd_a_q[NW] ? a_q : anc_rd_a_q[NW-1:0];

  assign path_sum   = (PW + 1)'(dhi_q) + (PW + 1)'(dlo_q) + (PW + 1)'(1);
  assign path_twice = (PW + 1)'({dep_rd_a_q, 1'b0});
  assign path_diff  = path_sum - path_twice;

  always_comb begin
    if (path_sum <= path_twice) begin
      path_val = PW'(1);
    end else if (path_diff > (PW + 1)'(tlca_pkg::PATH_MAX)) begin
      path_val = tlca_pkg::PATH_MAX;
    end else begin
      path_val = path_diff[PW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    half_d      = half_q;
    dhi_d       = dhi_q;
    dlo_d       = dlo_q;
    diff_d      = diff_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    dep_ra_a    = a_q;
    dep_ra_b    = b_q;
    dep_we      = 1'b0;
    dep_wa      = a_q;
    dep_wd      = '0;
    anc_rl_a    = '0;
    anc_rn_a    = a_q;
    anc_rl_b    = '0;
    anc_rn_b    = b_q;
    anc_we      = 1'b0;
    anc_wl      = k_q;
    anc_wn      = a_q;
    anc_wd      = tlca_pkg::NONE_ENTRY;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          a_d   = cmd_i.a;
          b_d   = cmd_i.b;
          k_d   = '0;
          case (cmd_i.op)
            tlca_pkg::OP_ROOT:  state_d = ST_ROOT;
            tlca_pkg::OP_LOAD:  state_d = ST_LD_RD;
            tlca_pkg::OP_QUERY: state_d = ST_Q_DEP;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROOT: begin
        dep_we = (k_q == '0);
        anc_we = 1'b1;
        if (k_q == LAST_LVL) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_LD_RD: begin
        anc_we   = 1'b1;
        anc_wl   = '0;
        anc_wd   = {1'b0, b_q};
        anc_rn_a = b_q;
        dep_ra_a = b_q;
        half_d   = {1'b0, b_q};
        k_d      = CNT_W'(1);
        state_d  = ST_LD_LVL;
      end
      ST_LD_LVL: begin
        if (k_q == CNT_W'(1)) begin
          dep_we = 1'b1;
          dep_wd = (dep_rd_a_q == tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX
                                                       : dep_rd_a_q + DW'(1);
        end
        if (k_q < NUM_LVL) begin
          anc_we = 1'b1;
          anc_wd = lvl_val;
        end
        half_d   = lvl_val;
        anc_rl_a = k_q;
        anc_rn_a = lvl_val[NW-1:0];
        if (k_q >= LAST_LVL) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_Q_DEP: begin
        state_d = ST_Q_SW;
      end
      ST_Q_SW: begin
        if (dep_rd_a_q < dep_rd_b_q) begin
          a_d   = b_q;
          b_d   = a_q;
          dhi_d = dep_rd_b_q;
          dlo_d = dep_rd_a_q;
        end else begin
          dhi_d = dep_rd_a_q;
          dlo_d = dep_rd_b_q;
        end
        diff_d   = dhi_d - dlo_d;
        anc_rn_a = a_d;
        k_d      = '0;
        state_d  = ST_Q_UP;
      end
      ST_Q_UP: begin
        a_d      = up_node;
        diff_d   = diff_q >> 1;
        anc_rl_a = k_q + CNT_W'(1);
        anc_rn_a = up_node;
        if (k_q == LAST_LVL) begin
          state_d = ST_Q_EQ;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_Q_EQ: begin
        if (a_q == b_q) begin
          c_d     = a_q;
          state_d = ST_Q_FIN;
        end else begin
          state_d = ST_Q_TOP;
        end
      end
      ST_Q_TOP: begin
        k_d      = top_lvl;
        anc_rl_a = top_lvl;
        anc_rl_b = top_lvl;
        state_d  = ST_Q_DN;
      end
      ST_Q_DN: begin
        a_d      = dn_a;
        b_d      = dn_b;
        anc_rl_a = dn_lvl;
        anc_rn_a = dn_a;
        anc_rl_b = dn_lvl;
        anc_rn_b = dn_b;
        if (k_q == '0) begin
          state_d = ST_Q_PAR;
        end else begin
          k_d = dn_lvl;
        end
      end
      ST_Q_PAR: begin
        c_d      = par_node;
        dep_ra_a = par_node;
        state_d  = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        res_valid_d      = 1'b1;
        res_d.ancestor   = c_q;
        res_d.path_nodes = path_val;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign anc_byp = anc_we && (anc_wl[LVL_W-1:0] == anc_rl_a[LVL_W-1:0])
                          && (anc_wn == anc_rn_a);

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[IDX_W'(dep_wa)] <= dep_wd;
    end
    dep_rd_a_q <= dep_mem[IDX_W'(dep_ra_a)];
    dep_rd_b_q <= dep_mem[IDX_W'(dep_ra_b)];
  end

  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[anc_wl[LVL_W-1:0]][IDX_W'(anc_wn)] <= anc_wd;
    end
    anc_rd_a_q <= anc_byp ? anc_wd : anc_mem[anc_rl_a[LVL_W-1:0]][IDX_W'(anc_rn_a)];
    anc_rd_b_q <= anc_mem[anc_rl_b[LVL_W-1:0]][IDX_W'(anc_rn_b)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    half_q <= half_d;
    dhi_q  <= dhi_d;
    dlo_q  <= dlo_d;
    diff_q <= diff_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/tree_lca_binary_lifting.sv =====
// Channel   Handshake              Payload
// input     start / busy           item_i   (tlca_pkg::tlca_in_t)
// result    result_valid_o strobe  result_o (tlca_pkg::tlca_res_t)
//
// The front takes one item at a time, wrapping node numbers when MAX_NODES < 2**18 (by
// reciprocal multiply, subtract and correct), queues it two deep and holds busy while full.
// The back runs one item at a time off the shared lift tables (root load, child load or
// query), a query's result strobing in the cycle after its final state.
// Reset clears control only; both tables hold garbage until written, no clearing pass.
// The receiver cannot stall: each result is a one-cycle strobe on result_valid_o.
`default_nettype none

module tree_lca_binary_lifting #(
  parameter int MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tlca_pkg::tlca_in_t  item_i,
  output logic                result_valid_o,
  output tlca_pkg::tlca_res_t result_o
);

  tlca_pkg::tlca_qstat_t q_stat;
  tlca_pkg::tlca_cmd_t   push_cmd, head_cmd;
  logic                  push, pop;

  tlca_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .q_stat_i(q_stat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  tlca_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (push_cmd),
    .pop_i (pop),
    .stat_o(q_stat),
    .cmd_o (head_cmd)
  );

  tlca_back #(
    .MAX_NODES  (MAX_NODES),
    .LIFT_LEVELS(LIFT_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tlca_checker.sv =====
`default_nettype none

module tlca_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input tlca_pkg::tlca_res_t result_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer accepted without front going busy");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  a_path_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.path_nodes != '0))
    else $error("path count of zero");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

`default_nettype wire
